// ===== rtl/hns_pkg.sv =====
// Shared constants and types of the heightmap normal stencil.
// No dependencies; the interfaces, the top level and the testbench import this package.
`default_nettype none

package hns_pkg;

    localparam int HEIGHT_W      = 16;   // Q8.8 height sample
    localparam int NORM_W        = 16;   // signed Q1.14 normal component
    localparam int NORMY_W       = 15;   // unsigned Q1.14 normal y
    localparam int ROW_W         = 16;
    localparam int COL_W         = 10;   // point_column port width
    localparam int COLS_REG_W    = 11;   // grid_columns register width
    localparam int CFG_W         = 16;   // widest register
    localparam int CFG_IDX_W     = 2;

    localparam int MAX_COLUMNS_DEF = 1024;

    localparam logic [COLS_REG_W-1:0] GRID_COLUMNS_RST = COLS_REG_W'(1024);
    localparam logic [ROW_W-1:0]      GRID_ROWS_RST    = ROW_W'(1024);

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX_RST = {1'b1, {(HEIGHT_W-1){1'b0}}};
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN_RST = {1'b0, {(HEIGHT_W-1){1'b1}}};

    // Squared length of the constant y term (256 in Q8.8).
    localparam logic [34:0] Y_SQ = 35'd65536;

    localparam int DIV_STEPS  = 31;  // quotient bits, quotient <= 2^30
    localparam int SQRT_STEPS = 16;  // root bits of a 31-bit value

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } comp_t;

endpackage

`default_nettype wire

// ===== rtl/hns_if.sv =====
// Valid/ready channel interfaces of the heightmap normal stencil.
// Depends on hns_pkg for field widths.
`default_nettype none

interface hns_in_if;
    import hns_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [HEIGHT_W-1:0] height;

    modport source (output valid, action, height, input ready);
    modport sink   (input valid, action, height, output ready);
endinterface

interface hns_out_if;
    import hns_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [NORM_W-1:0]   normal_x;
    logic [NORMY_W-1:0]         normal_y;
    logic signed [NORM_W-1:0]   normal_z;
    logic [ROW_W-1:0]           point_row;
    logic [COL_W-1:0]           point_column;
    logic                       frame_end;
    logic signed [HEIGHT_W-1:0] height_max;
    logic signed [HEIGHT_W-1:0] height_min;

    modport source (output valid, normal_x, normal_y, normal_z, point_row, point_column,
                    frame_end, height_max, height_min, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, point_row, point_column,
                    frame_end, height_max, height_min, output ready);
endinterface

`default_nettype wire

// ===== rtl/heightmap_normal_stencil.sv =====
// Top level of the heightmap normal stencil: row stores, sequencer, normalizer.
// Depends on hns_pkg, hns_if (hns_in_if, hns_out_if) and hns_ram.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+--------------------------------------------
//  samples   | in  | valid / ready  | action, height
//  normals   | out | valid / ready  | normal_x/y/z, point_row, point_column,
//            |     |                | frame_end, height_max, height_min
//  cfg       | in  | cfg_we         | cfg_index, cfg_wdata (no read-back)
//
// A sample that yields a normal, or a drain tick, passes the row-store reads
// (RD1, RD2 and, on a drain, RD3), difference, square and sum, then per component
// a load, the shared divider (31 steps) and the square-root unit (16 steps).
// A first-row sample only updates the row stores; an ignored transaction is dropped in idle.
// samples.ready is high only while the sequencer is idle and no register write is
// under way; the finished normal sits in the output register, so a new transaction
// is taken while it waits.
// Reset clears control state only; the row stores start undefined.
`default_nettype none

module heightmap_normal_stencil #(
    parameter int MAX_COLUMNS = hns_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hns_in_if.sink                             samples,
    hns_out_if.source                          normals,
    input  wire logic                          cfg_we,
    input  wire logic [hns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hns_pkg::CFG_W-1:0]     cfg_wdata
);

    import hns_pkg::*;

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int EW = (AW + 1 > COLS_REG_W) ? AW + 1 : COLS_REG_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_DIFF, ST_SQR, ST_SUM,
        ST_LOAD, ST_DIV, ST_SQRT, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration and frame position
    logic [COLS_REG_W-1:0]      grid_columns_reg;
    logic [ROW_W-1:0]           grid_rows_reg;
    logic [ROW_W-1:0]           input_row_reg;
    logic [AW-1:0]              input_column_reg;
    logic [AW-1:0]              drain_column_reg;
    logic                       drain_pending_reg;
    logic signed [HEIGHT_W-1:0] running_max_reg;
    logic signed [HEIGHT_W-1:0] running_min_reg;

    // the transaction at work
    logic [AW-1:0]              item_c_reg;
    logic signed [HEIGHT_W-1:0] item_h_reg;
    logic [ROW_W-1:0]           item_row_reg;
    logic                       item_left_ok_reg;
    logic                       item_right_ok_reg;
    logic                       item_top_ok_reg;
    logic                       item_drain_reg;
    logic                       item_emit_reg;
    logic                       item_last_reg;

    logic signed [HEIGHT_W-1:0] ctr_reg;
    logic signed [HEIGHT_W-1:0] top_reg;
    logic signed [HEIGHT_W-1:0] left_reg;
    logic signed [HEIGHT_W-1:0] right_reg;

    // normalizer
    logic                       negx_reg;
    logic                       negz_reg;
    logic [16:0]                magx_reg;
    logic [16:0]                magz_reg;
    logic [33:0]                sqx_reg;
    logic [33:0]                sqz_reg;
    logic [34:0]                s_reg;
    logic [35:0]                rem_reg;
    logic [30:0]                quo_reg;
    logic [30:0]                sq_rem_reg;
    logic [30:0]                root_reg;
    logic [30:0]                bit_reg;
    logic [4:0]                 step_reg;
    comp_t                      comp_reg;
    logic signed [NORM_W-1:0]   res_x_reg;
    logic [NORMY_W-1:0]         res_y_reg;
    logic signed [NORM_W-1:0]   res_z_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [NORM_W-1:0]   out_x_reg;
    logic [NORMY_W-1:0]         out_y_reg;
    logic signed [NORM_W-1:0]   out_z_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic                       out_end_reg;
    logic signed [HEIGHT_W-1:0] out_max_reg;
    logic signed [HEIGHT_W-1:0] out_min_reg;

    // row stores
    logic                       store_we;
    logic [AW-1:0]              newer_raddr;
    logic [AW-1:0]              older_raddr;
    logic [HEIGHT_W-1:0]        newer_q;
    logic [HEIGHT_W-1:0]        older_q;

    // decode of an incoming transaction
    logic [EW-1:0]              eff_cols;
    logic [ROW_W-1:0]           eff_rows;
    logic                       in_fire;
    logic                       take_drain;
    logic                       take_sample;
    logic [AW-1:0]              acc_c;
    logic [EW-1:0]              acc_c_next;
    logic                       last_col;
    logic                       last_row;

    // datapath helpers
    logic signed [16:0]         dl;
    logic signed [16:0]         dr;
    logic signed [16:0]         dt;
    logic signed [16:0]         db;
    logic signed [17:0]         dx;
    logic signed [17:0]         dz;
    logic [35:0]                div_t;
    logic                       div_ge;
    logic [30:0]                quo_next;
    logic [30:0]                sq_trial;
    logic                       sq_ge;
    logic [30:0]                root_next;
    logic [NORMY_W-1:0]         m_val;
    logic signed [NORM_W-1:0]   m_signed;
    logic                       out_load;

    hns_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_COLUMNS)) u_older_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (item_c_reg),
        .wdata (ctr_reg),
        .raddr (older_raddr),
        .rdata (older_q)
    );

    hns_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_COLUMNS)) u_newer_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (item_c_reg),
        .wdata (item_h_reg),
        .raddr (newer_raddr),
        .rdata (newer_q)
    );

    assign samples.ready        = (state_reg == ST_IDLE) && !cfg_we;
    assign normals.valid        = out_valid_reg;
    assign normals.normal_x     = out_x_reg;
    assign normals.normal_y     = out_y_reg;
    assign normals.normal_z     = out_z_reg;
    assign normals.point_row    = out_row_reg;
    assign normals.point_column = out_col_reg;
    assign normals.frame_end    = out_end_reg;
    assign normals.height_max   = out_max_reg;
    assign normals.height_min   = out_min_reg;

    // Effective grid size: zero means one, columns clamp to the store depth.
    always_comb
    begin
        if (grid_columns_reg == '0)
        begin
            eff_cols = EW'(1);
        end
        else if (EW'(grid_columns_reg) > EW'(MAX_COLUMNS))
        begin
            eff_cols = EW'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = EW'(grid_columns_reg);
        end
        eff_rows = (grid_rows_reg == '0) ? ROW_W'(1) : grid_rows_reg;
    end

    // Classify the offered transaction: flush ticks only count while draining,
    // samples only while not.
    always_comb
    begin
        in_fire     = samples.valid && samples.ready;
        take_drain  = samples.action && drain_pending_reg;
        take_sample = !samples.action && !drain_pending_reg;
        acc_c       = take_drain ? drain_column_reg : input_column_reg;
        acc_c_next  = EW'(acc_c) + EW'(1);
        last_col    = (acc_c_next >= eff_cols);
        last_row    = ((17'(input_row_reg) + 17'd1) >= 17'(eff_rows));
    end

    // Row-store read ports: centre and top at accept, then right/left
    // neighbours, then the left neighbour of the last row on a drain.
    always_comb
    begin
        newer_raddr = acc_c;
        older_raddr = acc_c;
        unique case (state_reg)
            ST_RD1:
            begin
                newer_raddr = item_c_reg + AW'(1);
                older_raddr = item_c_reg - AW'(1);
            end
            ST_RD2:
            begin
                newer_raddr = item_c_reg - AW'(1);
                older_raddr = item_c_reg;
            end
            default:
            begin
                newer_raddr = acc_c;
                older_raddr = acc_c;
            end
        endcase
        store_we = (state_reg == ST_RD2) && !item_drain_reg;
    end

    // Stencil differences; a missing neighbour contributes nothing.
    always_comb
    begin
        dl = item_left_ok_reg  ? ({left_reg[15],  left_reg}  - {ctr_reg[15], ctr_reg}) : '0;
        dr = item_right_ok_reg ? ({right_reg[15], right_reg} - {ctr_reg[15], ctr_reg}) : '0;
        dt = item_top_ok_reg   ? ({top_reg[15],   top_reg}   - {ctr_reg[15], ctr_reg}) : '0;
        db = !item_drain_reg   ? ({item_h_reg[15], item_h_reg} - {ctr_reg[15], ctr_reg}) : '0;
        dx = {dl[16], dl} - {dr[16], dr};
        dz = {dt[16], dt} - {db[16], db};
    end

    // Shared divider and square-root steps.
    // Q = floor(c^2 * 2^30 / s); result m = floor((isqrt(Q) + 1) / 2).
    always_comb
    begin
        div_t     = (step_reg == '0) ? rem_reg : {rem_reg[34:0], 1'b0};
        div_ge    = (div_t >= {1'b0, s_reg});
        quo_next  = {quo_reg[29:0], div_ge};
        sq_trial  = root_reg + bit_reg;
        sq_ge     = (sq_rem_reg >= sq_trial);
        root_next = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
        m_val     = NORMY_W'((17'(root_next[15:0]) + 17'd1) >> 1);
        m_signed  = NORM_W'(m_val);
        out_load  = (state_reg == ST_OUT) && (!out_valid_reg || normals.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            grid_columns_reg  <= GRID_COLUMNS_RST;
            grid_rows_reg     <= GRID_ROWS_RST;
            input_row_reg     <= '0;
            input_column_reg  <= '0;
            drain_column_reg  <= '0;
            drain_pending_reg <= 1'b0;
            running_max_reg   <= HEIGHT_MAX_RST;
            running_min_reg   <= HEIGHT_MIN_RST;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
            comp_reg          <= COMP_X;
        end
        else
        begin
            // Load a finished normal when the register frees up; drop the held one once taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (normals.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Writes to either grid register restart the frame; stores and extremes stay.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_COLUMNS:
                    begin
                        grid_columns_reg  <= cfg_wdata[COLS_REG_W-1:0];
                        input_row_reg     <= '0;
                        input_column_reg  <= '0;
                        drain_column_reg  <= '0;
                        drain_pending_reg <= 1'b0;
                    end
                    REG_GRID_ROWS:
                    begin
                        grid_rows_reg     <= cfg_wdata[ROW_W-1:0];
                        input_row_reg     <= '0;
                        input_column_reg  <= '0;
                        drain_column_reg  <= '0;
                        drain_pending_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && take_drain)
                    begin
                        item_c_reg        <= acc_c;
                        item_row_reg      <= eff_rows - ROW_W'(1);
                        item_left_ok_reg  <= (acc_c != '0);
                        item_right_ok_reg <= !last_col;
                        item_top_ok_reg   <= (eff_rows > ROW_W'(1));
                        item_drain_reg    <= 1'b1;
                        item_emit_reg     <= 1'b1;
                        item_last_reg     <= last_col;
                        if (last_col)
                        begin
                            drain_column_reg  <= '0;
                            drain_pending_reg <= 1'b0;
                        end
                        else
                        begin
                            drain_column_reg <= AW'(acc_c_next);
                        end
                        state_reg <= ST_RD1;
                    end
                    else if (in_fire && take_sample)
                    begin
                        item_c_reg        <= acc_c;
                        item_h_reg        <= samples.height;
                        item_row_reg      <= input_row_reg - ROW_W'(1);
                        item_left_ok_reg  <= (acc_c != '0);
                        item_right_ok_reg <= !last_col;
                        item_top_ok_reg   <= (input_row_reg >= ROW_W'(2));
                        item_drain_reg    <= 1'b0;
                        item_emit_reg     <= (input_row_reg != '0);
                        item_last_reg     <= 1'b0;
                        if (samples.height > running_max_reg)
                        begin
                            running_max_reg <= samples.height;
                        end
                        if (samples.height < running_min_reg)
                        begin
                            running_min_reg <= samples.height;
                        end
                        // advance the raster position
                        if (last_col)
                        begin
                            input_column_reg <= '0;
                            if (last_row)
                            begin
                                input_row_reg     <= '0;
                                drain_pending_reg <= 1'b1;
                                drain_column_reg  <= '0;
                            end
                            else
                            begin
                                input_row_reg <= input_row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            input_column_reg <= AW'(acc_c_next);
                        end
                        state_reg <= ST_RD1;
                    end
                end
                ST_RD1:
                begin
                    ctr_reg   <= newer_q;
                    top_reg   <= older_q;
                    state_reg <= ST_RD2;
                end
                ST_RD2:
                begin
                    right_reg <= newer_q;
                    left_reg  <= older_q;
                    if (item_drain_reg)
                    begin
                        state_reg <= ST_RD3;
                    end
                    else if (item_emit_reg)
                    begin
                        state_reg <= ST_DIFF;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD3:
                begin
                    // on a drain the left neighbour sits in the newer row
                    left_reg  <= newer_q;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    negx_reg  <= dx[17];
                    negz_reg  <= dz[17];
                    magx_reg  <= dx[17] ? 17'(-dx) : dx[16:0];
                    magz_reg  <= dz[17] ? 17'(-dz) : dz[16:0];
                    state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    sqx_reg   <= 34'(magx_reg) * 34'(magx_reg);
                    sqz_reg   <= 34'(magz_reg) * 34'(magz_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    s_reg     <= 35'(sqx_reg) + 35'(sqz_reg) + Y_SQ;
                    comp_reg  <= COMP_X;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    unique case (comp_reg)
                        COMP_X:  rem_reg <= 36'(sqx_reg);
                        COMP_Y:  rem_reg <= 36'(Y_SQ);
                        default: rem_reg <= 36'(sqz_reg);
                    endcase
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= div_ge ? (div_t - {1'b0, s_reg}) : div_t;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        sq_rem_reg <= quo_next;
                        root_reg   <= '0;
                        bit_reg    <= 31'(1) << 30;
                        step_reg   <= '0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_rem_reg <= sq_rem_reg - sq_trial;
                    end
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(SQRT_STEPS - 1))
                    begin
                        unique case (comp_reg)
                            COMP_X:
                            begin
                                res_x_reg <= negx_reg ? -m_signed : m_signed;
                                comp_reg  <= COMP_Y;
                                state_reg <= ST_LOAD;
                            end
                            COMP_Y:
                            begin
                                res_y_reg <= m_val;
                                comp_reg  <= COMP_Z;
                                state_reg <= ST_LOAD;
                            end
                            default:
                            begin
                                res_z_reg <= negz_reg ? -m_signed : m_signed;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        out_x_reg     <= res_x_reg;
                        out_y_reg     <= res_y_reg;
                        out_z_reg     <= res_z_reg;
                        out_row_reg   <= item_row_reg;
                        out_col_reg   <= COL_W'(item_c_reg);
                        out_end_reg   <= item_last_reg;
                        out_max_reg   <= running_max_reg;
                        out_min_reg   <= running_min_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hns_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/heightmap_normal_stencil_test.sv =====
// Self-checking testbench for heightmap_normal_stencil: raster height frames, flush drains
// and register writes, checked against an internal bit-exact predictor of the normals.
// Depends on hns_pkg and the hns_in_if / hns_out_if channel interfaces of the RTL.
`default_nettype none

module heightmap_normal_stencil_test;
    import hns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 4;
    localparam int SETTLE_CYCLES = 200;    // covers one full normalizer pass
    localparam int STALL_LIMIT = 5000;     // cycles without any transaction
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 380;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [NORM_W-1:0]   nx;
        logic [NORMY_W-1:0]         ny;
        logic signed [NORM_W-1:0]   nz;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       last;
        logic signed [HEIGHT_W-1:0] hmax;
        logic signed [HEIGHT_W-1:0] hmin;
    } normal_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    hns_in_if samples ();
    hns_out_if normals ();

    heightmap_normal_stencil u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples.sink),
        .normals   (normals.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: a private copy of the row stores, raster position and extremes.
    int older_row[MAX_COLUMNS_DEF];
    int newer_row[MAX_COLUMNS_DEF];
    int unsigned raster_row, raster_col, drain_col;
    bit draining;
    int peak_height, floor_height;
    int unsigned columns_reg, rows_reg;

    normal_t normals_due[$];

    int send_idle_pct, recv_stall_pct;
    int errors, normals_checked, items_taken, frames_sent;

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Receiver: decide back-pressure for the next edge on every falling edge.
    always @(negedge clk)
    begin
        normals.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Round(c * 2^14 / sqrt(s)) with halves away from zero, found bit by bit:
    // keep a candidate m while (2m-1)^2 * s <= (2^15 |c|)^2.
    function automatic int q14_component(longint c, longint unsigned s);
        longint unsigned mag, b, t;
        logic [127:0] lhs, rhs;
        int unsigned m, cand;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        b = mag << 15;
        m = 0;
        rhs = 128'(b) * 128'(b);
        for (int bi = 14; bi >= 0; bi--)
        begin
            cand = m | (32'd1 << bi);
            t = 2 * longint'(cand) - 1;
            lhs = 128'(t * t) * 128'(s);
            if (cand <= 16384 && lhs <= rhs)
                m = cand;
        end
        return (c < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic void queue_normal(longint x, longint z, int unsigned row,
                                         int unsigned col, bit last);
        longint unsigned s;
        normal_t n;
        s = longint'(x * x) + 65536 + longint'(z * z);
        n.nx = NORM_W'(q14_component(x, s));
        n.ny = NORMY_W'(q14_component(256, s));
        n.nz = NORM_W'(q14_component(z, s));
        n.row = ROW_W'(row);
        n.col = COL_W'(col);
        n.last = last;
        n.hmax = HEIGHT_W'(peak_height);
        n.hmin = HEIGHT_W'(floor_height);
        normals_due.push_back(n);
    endfunction

    function automatic int unsigned used_columns();
        if (columns_reg == 0) return 1;
        if (columns_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
        return columns_reg;
    endfunction

    // Advance the predictor by one accepted transaction; return 0 when the block ignores it.
    function automatic bit predict_normal(bit flush, logic signed [HEIGHT_W-1:0] h_in);
        int unsigned cols, rows, c, r;
        longint h, x, z, ctr;
        cols = used_columns();
        rows = (rows_reg == 0) ? 1 : rows_reg;
        x = 0;
        z = 0;
        if (flush)
        begin
            if (!draining) return 0;
            c = drain_col % cols;
            h = newer_row[c];
            if (c > 0) x += newer_row[c-1] - h;
            if (c + 1 < cols) x -= newer_row[c+1] - h;
            if (rows > 1) z += older_row[c] - h;
            queue_normal(x, z, rows - 1, c, c + 1 == cols);
            if (c + 1 >= cols)
            begin
                drain_col = 0;
                draining = 0;
            end
            else
                drain_col = c + 1;
            return 1;
        end
        if (draining) return 0;
        h = h_in;
        if (h > peak_height) peak_height = int'(h);
        if (h < floor_height) floor_height = int'(h);
        c = raster_col % cols;
        r = raster_row % rows;
        if (r >= 1)
        begin
            ctr = newer_row[c];
            if (c > 0) x += older_row[c-1] - ctr;
            if (c + 1 < cols) x -= newer_row[c+1] - ctr;
            if (r >= 2) z += older_row[c] - ctr;
            z -= h - ctr;
            queue_normal(x, z, r - 1, c, 1'b0);
        end
        older_row[c] = newer_row[c];
        newer_row[c] = int'(h);
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
            begin
                r = 0;
                draining = 1;
                drain_col = 0;
            end
        end
        raster_col = c;
        raster_row = r;
        return 1;
    endfunction

    // Check every normal against the oldest expectation.
    always @(posedge clk)
    begin
        normal_t got, want;
        if (rst_n && normals.valid && normals.ready)
        begin
            got = '{normals.normal_x, normals.normal_y, normals.normal_z, normals.point_row,
                    normals.point_column, normals.frame_end, normals.height_max,
                    normals.height_min};
            if (normals_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected normal at row %0d col %0d", got.row, got.col);
            end
            else
            begin
                want = normals_due.pop_front();
                normals_checked++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("ERROR: normal mismatch at %0t", $realtime);
                        $display("  expected n=(%0d,%0d,%0d) pt=(%0d,%0d) end=%0d max=%0d min=%0d",
                                 want.nx, want.ny, want.nz, want.row, want.col, want.last,
                                 want.hmax, want.hmin);
                        $display("  actual   n=(%0d,%0d,%0d) pt=(%0d,%0d) end=%0d max=%0d min=%0d",
                                 got.nx, got.ny, got.nz, got.row, got.col, got.last,
                                 got.hmax, got.hmin);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (samples.valid && samples.ready) || (normals.valid && normals.ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one transaction: drive on the falling edge, hold until accepted, then predict.
    task automatic send_item(bit flush, logic signed [HEIGHT_W-1:0] h);
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(1, 6)) @(negedge clk);
        samples.valid = 1'b1;
        samples.action = flush;
        samples.height = h;
        do
            @(posedge clk);
        while (!samples.ready);
        if (predict_normal(flush, h))
            items_taken++;
        @(negedge clk);
        samples.valid = 1'b0;
    endtask

    // Hold until every expected normal is out, then let the normalizer settle.
    task automatic wait_drained();
        while (normals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_GRID_COLUMNS || idx == REG_GRID_ROWS)
        begin
            if (idx == REG_GRID_COLUMNS)
                columns_reg = value & 16'h07FF;
            else
                rows_reg = value;
            raster_row = 0;
            raster_col = 0;
            drain_col = 0;
            draining = 0;
        end
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows);
        write_reg(REG_GRID_COLUMNS, CFG_W'(cols));
        write_reg(REG_GRID_ROWS, CFG_W'(rows));
    endtask

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        if ($urandom_range(3) == 0)
            return HEIGHT_W'($urandom);
        return HEIGHT_W'(int'($urandom_range(1023)) - 512);
    endfunction

    // Directed: height extremes, flush outside a drain, samples during a drain, edge sizes.
    task automatic test_directed();
        logic signed [HEIGHT_W-1:0] pattern [9] = '{16'sh7FFF, -16'sh8000, 16'sh0000,
                                                    16'sh5555, -16'sh5556, 16'sh0001,
                                                    -16'sh0001, 16'sh7FFF, -16'sh8000};
        set_grid(3, 3);
        send_item(1'b1, 16'sh1234);           // flush with nothing to drain: dropped
        foreach (pattern[i])
            send_item(1'b0, pattern[i]);
        send_item(1'b1, '0);
        send_item(1'b0, 16'sh2222);           // sample during a drain: dropped
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        send_item(1'b1, '0);                  // drain done: dropped
        // Zero registers act as a 1 x 1 grid.
        set_grid(0, 0);
        send_item(1'b0, 16'sh0100);
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        // Single column with two rows: no left or right neighbour.
        set_grid(1, 2);
        send_item(1'b0, -16'sh0100);
        send_item(1'b0, 16'sh0300);
        send_item(1'b1, '0);
    endtask

    // Register extremes: clamped column count over a full-width row and the start of its
    // drain, largest row count, and a write to an unused index in the middle of a frame
    // (no restart).
    task automatic test_register_extremes();
        set_grid(2047, 1);
        repeat (MAX_COLUMNS_DEF) send_item(1'b0, random_height());
        repeat (4) send_item(1'b1, '0);
        set_grid(2, 65535);
        repeat (4) send_item(1'b0, random_height());
        write_reg(REG_UNUSED, 16'hFFFF);
        repeat (3) send_item(1'b0, random_height());
        set_grid(1024, 1024);
        repeat (5) send_item(1'b0, random_height());
    endtask

    // One frame of random heights plus its drain, with some dropped noise and
    // occasionally an abandoned frame.
    task automatic send_frame(bit hold_midway);
        int unsigned cols, rows, points, cut;
        cols = ($urandom_range(19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        rows = $urandom_range(1, 5);
        set_grid(cols, rows);
        points = cols * rows;
        cut = ($urandom_range(9) == 0) ? $urandom_range(points) : points;
        for (int unsigned i = 0; i < cut; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(1'b1, random_height());
            if (hold_midway && i == cut / 2)
                wait_drained();
            send_item(1'b0, random_height());
        end
        if (cut == points)
        begin
            for (int unsigned i = 0; i < cols; i++)
            begin
                if ($urandom_range(19) == 0)
                    send_item(1'b0, random_height());
                send_item(1'b1, '0);
            end
        end
        frames_sent++;
    endtask

    task automatic test_random_frames();
        int quota;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            quota = items_taken + RANDOM_ITEMS / 4;
            send_frame(ph == 2);
            while (items_taken < quota)
                send_frame(1'b0);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_COLUMNS;
        cfg_wdata = '0;
        samples.valid = 1'b0;
        samples.action = 1'b0;
        samples.height = '0;
        normals.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (older_row[i])
        begin
            older_row[i] = 0;
            newer_row[i] = 0;
        end
        raster_row = 0;
        raster_col = 0;
        drain_col = 0;
        draining = 0;
        peak_height = -32768;
        floor_height = 32767;
        columns_reg = GRID_COLUMNS_RST;
        rows_reg = GRID_ROWS_RST;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_random_frames();

        wait_drained();
        $display("Covered %0d frames and %0d effective transactions; %0d normals checked.",
                 frames_sent, items_taken, normals_checked);
        $display("Mismatches: %0d", errors);
        if (errors == 0 && normals_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== heightmap_normal_stencil.f =====
rtl/hns_pkg.sv
rtl/hns_if.sv
rtl/hns_ram.sv
rtl/heightmap_normal_stencil.sv
tb/heightmap_normal_stencil_test.sv
